>>> rtl/ggvc_pkg.sv
package ggvc_pkg;

    // Datapath widths
    localparam int DXW = 33;   // world error, Q16.16
    localparam int XW1 = 35;   // yaw CORDIC x/y
    localparam int UW  = 36;   // rotated error u/v
    localparam int ZW  = 28;   // angles, Q.24 rad
    localparam int BW  = 35;   // body error
    localparam int XW2 = 45;   // bearing CORDIC x/y
    localparam int DW  = 29;   // heading error
    localparam int CW  = 31;   // config data width

    localparam logic signed [ZW-1:0] HALF_PI_Q = 28'sd26353589;
    localparam logic signed [DW-1:0] PI_Q      = 29'sd52707179;
    localparam logic signed [DW-1:0] TWO_PI_Q  = 29'sd105414357;
    localparam logic [23:0]          INV_GAIN  = 24'd10188014;

    typedef enum logic [2:0] {
        CFG_FORWARD_GAIN  = 3'd0,
        CFG_TURN_GAIN     = 3'd1,
        CFG_SPEED_UPPER   = 3'd2,
        CFG_SPEED_LOWER   = 3'd3,
        CFG_ROTATE_RADIUS = 3'd4,
        CFG_ARRIVE_RADIUS = 3'd5,
        CFG_HEADING_TOL   = 3'd6,
        CFG_FINAL_HEADING = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               path_valid;
        logic signed [31:0] goal_north;
        logic signed [31:0] goal_east;
        logic signed [31:0] pos_north;
        logic signed [31:0] pos_east;
        logic signed [15:0] rot_row0_col0;
        logic signed [15:0] rot_row1_col0;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] forward_speed;
        logic signed [15:0] yaw_rate;
        logic               arrived;
    } t_res;

    // Side info riding along the yaw CORDIC
    typedef struct packed {
        logic path;
        logic deg;
        logic near_rot;
        logic near_arr;
    } t_m1;

    // Side info riding along the bearing CORDIC
    typedef struct packed {
        logic                  path;
        logic                  near_rot;
        logic                  near_arr;
        logic                  zero;
        logic signed [ZW-1:0]  yaw;
        logic signed [15:0]    vel;
    } t_m2;

    // atan(2^-i) in Q.24 radians
    function automatic logic signed [ZW-1:0] atan_q(input int unsigned i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 28'sd13176795;
            1:  a = 28'sd7778716;
            2:  a = 28'sd4110060;
            3:  a = 28'sd2086331;
            4:  a = 28'sd1047214;
            5:  a = 28'sd524117;
            6:  a = 28'sd262123;
            7:  a = 28'sd131069;
            8:  a = 28'sd65536;
            9:  a = 28'sd32768;
            10: a = 28'sd16384;
            11: a = 28'sd8192;
            12: a = 28'sd4096;
            13: a = 28'sd2048;
            14: a = 28'sd1024;
            15: a = 28'sd512;
            16: a = 28'sd256;
            17: a = 28'sd128;
            18: a = 28'sd64;
            19: a = 28'sd32;
            20: a = 28'sd16;
            21: a = 28'sd8;
            22: a = 28'sd4;
            23: a = 28'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/go_to_goal_velocity_controller_core.sv
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+------------------------------------
// command   | start, busy, i_cmd                  | beat taken when start && !busy
// result    | o_valid, o_res                      | one-cycle strobe, no back-pressure
// config    | i_cfg_we, i_cfg_idx, i_cfg_data     | write when i_cfg_we is high
//
// Fully pipelined: one command beat per cycle, busy is never raised.
// A command passes stage S0 (world error), the yaw CORDIC, the gain-correction stages,
// the bearing CORDIC and stages F1 to F3 before the result strobe rises; the two
// unrolled CORDIC chains (yaw, then goal bearing) take one iteration a stage.
// Synchronous active-low reset clears the valid bits and loads the register reset values.
// The receiver cannot stall; results leave in order, one per accepted beat.
module go_to_goal_velocity_controller_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  ggvc_pkg::t_cmd           i_cmd,
    output logic                     o_valid,
    output ggvc_pkg::t_res           o_res,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [ggvc_pkg::CW-1:0]  i_cfg_data
);

    localparam int N   = CORDIC_STEPS;
    localparam int LAT = 2 * CORDIC_STEPS + 8;

    // ---------------- configuration registers ----------------
    logic        [15:0] r_fg, r_tg;
    logic signed [15:0] r_su, r_sl, r_fh;
    logic        [30:0] r_rrad, r_arad;
    logic        [14:0] r_htol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg   <= 16'd3277;
            r_tg   <= 16'd4096;
            r_su   <= 16'sd512;
            r_sl   <= -16'sd512;
            r_rrad <= 31'd6554;
            r_arad <= 31'd19661;
            r_htol <= 15'd2859;
            r_fh   <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ggvc_pkg::CFG_FORWARD_GAIN:  r_fg   <= i_cfg_data[15:0];
                ggvc_pkg::CFG_TURN_GAIN:     r_tg   <= i_cfg_data[15:0];
                ggvc_pkg::CFG_SPEED_UPPER:   r_su   <= i_cfg_data[15:0];
                ggvc_pkg::CFG_SPEED_LOWER:   r_sl   <= i_cfg_data[15:0];
                ggvc_pkg::CFG_ROTATE_RADIUS: r_rrad <= i_cfg_data[30:0];
                ggvc_pkg::CFG_ARRIVE_RADIUS: r_arad <= i_cfg_data[30:0];
                ggvc_pkg::CFG_HEADING_TOL:   r_htol <= i_cfg_data[14:0];
                ggvc_pkg::CFG_FINAL_HEADING: r_fh   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;
    logic acc;
    assign acc = start && !busy;

    // ---------------- stage S0: world error ----------------
    logic                               r_s0_v;
    logic signed [ggvc_pkg::DXW-1:0]    r_dx, r_dy;
    logic signed [15:0]                 r_r00, r_r10;
    logic                               r_path;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s0_v <= 1'b0;
        else          r_s0_v <= acc;
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= 33'(i_cmd.goal_north) - 33'(i_cmd.pos_north);
        r_dy   <= 33'(i_cmd.goal_east) - 33'(i_cmd.pos_east);
        r_r00  <= i_cmd.rot_row0_col0;
        r_r10  <= i_cmd.rot_row1_col0;
        r_path <= i_cmd.path_valid;
    end

    // ---------------- yaw CORDIC: pre-rotation + squares ----------------
    logic                            r_v1 [0:N];
    ggvc_pkg::t_m1                   r_m1 [0:N];
    logic signed [ggvc_pkg::XW1-1:0] r_x1 [0:N];
    logic signed [ggvc_pkg::XW1-1:0] r_y1 [0:N];
    logic signed [ggvc_pkg::UW-1:0]  r_u1 [0:N];
    logic signed [ggvc_pkg::UW-1:0]  r_w1 [0:N];
    logic signed [ggvc_pkg::ZW-1:0]  r_z1 [0:N];

    logic signed [ggvc_pkg::XW1-1:0] n_x0, n_y0, n_xa, n_ya;
    logic signed [ggvc_pkg::UW-1:0]  n_u0, n_w0, n_ua, n_wa;
    logic signed [ggvc_pkg::ZW-1:0]  n_z0;
    logic        [ggvc_pkg::DXW-1:0] n_ax, n_ay;
    logic [61:0] r_sqx, r_sqy, r_rr2, r_ra2;
    logic        r_ovf;

    always_comb begin
        n_xa = {{3{r_r00[15]}}, r_r00, 16'b0};
        n_ya = {{3{r_r10[15]}}, r_r10, 16'b0};
        n_ua = 36'(r_dx);
        n_wa = 36'(r_dy);
        n_x0 = n_xa;
        n_y0 = n_ya;
        n_u0 = n_ua;
        n_w0 = n_wa;
        n_z0 = '0;
        if (r_r00[15]) begin
            if (!r_r10[15]) begin
                n_x0 = n_ya;  n_y0 = -n_xa;
                n_u0 = n_wa;  n_w0 = -n_ua;
                n_z0 = ggvc_pkg::HALF_PI_Q;
            end else begin
                n_x0 = -n_ya; n_y0 = n_xa;
                n_u0 = -n_wa; n_w0 = n_ua;
                n_z0 = -ggvc_pkg::HALF_PI_Q;
            end
        end
        n_ax = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        n_ay = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1[0] <= 1'b0;
        else          r_v1[0] <= r_s0_v;
    end

    always_ff @(posedge i_clk) begin
        r_x1[0]          <= n_x0;
        r_y1[0]          <= n_y0;
        r_u1[0]          <= n_u0;
        r_w1[0]          <= n_w0;
        r_z1[0]          <= n_z0;
        r_m1[0].path     <= r_path;
        r_m1[0].deg      <= (r_r00 == 16'sd0) && (r_r10 == 16'sd0);
        r_m1[0].near_rot <= 1'b0;
        r_m1[0].near_arr <= 1'b0;
        // exact distance test needs both |dx| and |dy| under 2^31
        r_sqx <= 62'(n_ax[30:0]) * 62'(n_ax[30:0]);
        r_sqy <= 62'(n_ay[30:0]) * 62'(n_ay[30:0]);
        r_rr2 <= 62'(r_rrad) * 62'(r_rrad);
        r_ra2 <= 62'(r_arad) * 62'(r_arad);
        r_ovf <= (|n_ax[32:31]) || (|n_ay[32:31]);
    end

    logic [62:0] n_d2;
    assign n_d2 = 63'(r_sqx) + 63'(r_sqy);

    // ---------------- yaw CORDIC iterations ----------------
    for (genvar i = 0; i < N; i++) begin : g_cordic1
        logic signed [ggvc_pkg::XW1-1:0] xs, ys;
        logic signed [ggvc_pkg::UW-1:0]  us, ws;
        ggvc_pkg::t_m1                   n_m1;
        assign xs = r_x1[i] >>> i;
        assign ys = r_y1[i] >>> i;
        assign us = r_u1[i] >>> i;
        assign ws = r_w1[i] >>> i;

        // first stage picks up the distance compares
        always_comb begin
            n_m1 = r_m1[i];
            if (i == 0) begin
                n_m1.near_rot = !r_ovf && (n_d2 < 63'(r_rr2));
                n_m1.near_arr = !r_ovf && (n_d2 < 63'(r_ra2));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v1[i+1] <= 1'b0;
            else          r_v1[i+1] <= r_v1[i];
        end

        always_ff @(posedge i_clk) begin
            r_m1[i+1] <= n_m1;
            if (r_y1[i][ggvc_pkg::XW1-1]) begin
                r_x1[i+1] <= r_x1[i] - ys;
                r_y1[i+1] <= r_y1[i] + xs;
                r_z1[i+1] <= r_z1[i] - ggvc_pkg::atan_q(i);
            end else begin
                r_x1[i+1] <= r_x1[i] + ys;
                r_y1[i+1] <= r_y1[i] - xs;
                r_z1[i+1] <= r_z1[i] + ggvc_pkg::atan_q(i);
            end
            // degenerate orientation: hold the world error unrotated
            if (r_m1[i].deg) begin
                r_u1[i+1] <= r_u1[i];
                r_w1[i+1] <= r_w1[i];
            end else if (r_y1[i][ggvc_pkg::XW1-1]) begin
                r_u1[i+1] <= r_u1[i] - ws;
                r_w1[i+1] <= r_w1[i] + us;
            end else begin
                r_u1[i+1] <= r_u1[i] + ws;
                r_w1[i+1] <= r_w1[i] - us;
            end
        end
    end

    // ---------------- gain correction: partial products, then sum ----------------
    logic                           r_g1_v, r_g2_v;
    ggvc_pkg::t_m1                  r_g1_m;
    logic [41:0]                    r_pul, r_pwl;
    logic signed [42:0]             r_puh, r_pwh;
    logic signed [ggvc_pkg::BW-1:0] r_g1_u, r_g1_w;
    logic signed [ggvc_pkg::ZW-1:0] r_g1_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_v <= 1'b0;
            r_g2_v <= 1'b0;
        end else begin
            r_g1_v <= r_v1[N];
            r_g2_v <= r_g1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1_m   <= r_m1[N];
        r_pul    <= 42'(r_u1[N][17:0]) * 42'(ggvc_pkg::INV_GAIN);
        r_pwl    <= 42'(r_w1[N][17:0]) * 42'(ggvc_pkg::INV_GAIN);
        r_puh    <= 43'($signed(r_u1[N][35:18])) * 43'($signed({1'b0, ggvc_pkg::INV_GAIN}));
        r_pwh    <= 43'($signed(r_w1[N][35:18])) * 43'($signed({1'b0, ggvc_pkg::INV_GAIN}));
        r_g1_u   <= r_u1[N][ggvc_pkg::BW-1:0];
        r_g1_w   <= r_w1[N][ggvc_pkg::BW-1:0];
        r_g1_yaw <= r_m1[N].deg ? '0 : r_z1[N];
    end

    logic [61:0] n_sbx, n_sby;
    assign n_sbx = (62'(r_puh) << 18) + 62'(r_pul) + 62'(1 << 23);
    assign n_sby = (62'(r_pwh) << 18) + 62'(r_pwl) + 62'(1 << 23);

    ggvc_pkg::t_m1                  r_g2_m;
    logic signed [ggvc_pkg::BW-1:0] r_bx, r_by;
    logic signed [ggvc_pkg::ZW-1:0] r_g2_yaw;

    always_ff @(posedge i_clk) begin
        r_g2_m   <= r_g1_m;
        r_g2_yaw <= r_g1_yaw;
        r_bx     <= r_g1_m.deg ? r_g1_u : $signed(n_sbx[58:24]);
        r_by     <= r_g1_m.deg ? r_g1_w : $signed(n_sby[58:24]);
    end

    // ---------------- bearing CORDIC: pre-rotation + speed products ----------------
    logic                            r_v2 [0:N];
    ggvc_pkg::t_m2                   r_m2 [0:N];
    logic signed [ggvc_pkg::XW2-1:0] r_x2 [0:N];
    logic signed [ggvc_pkg::XW2-1:0] r_y2 [0:N];
    logic signed [ggvc_pkg::ZW-1:0]  r_z2 [0:N];

    logic signed [ggvc_pkg::XW2-1:0] n_bxa, n_bya, n_x2, n_y2;
    logic signed [ggvc_pkg::ZW-1:0]  n_z2;
    logic        [33:0]              r_vql;
    logic signed [33:0]              r_vqh;

    always_comb begin
        n_bxa = {{2{r_bx[ggvc_pkg::BW-1]}}, r_bx, 8'b0};
        n_bya = {{2{r_by[ggvc_pkg::BW-1]}}, r_by, 8'b0};
        n_x2  = n_bxa;
        n_y2  = n_bya;
        n_z2  = '0;
        if (r_bx[ggvc_pkg::BW-1]) begin
            if (!r_by[ggvc_pkg::BW-1]) begin
                n_x2 = n_bya;  n_y2 = -n_bxa;
                n_z2 = ggvc_pkg::HALF_PI_Q;
            end else begin
                n_x2 = -n_bya; n_y2 = n_bxa;
                n_z2 = -ggvc_pkg::HALF_PI_Q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2[0] <= 1'b0;
        else          r_v2[0] <= r_g2_v;
    end

    always_ff @(posedge i_clk) begin
        r_x2[0]          <= n_x2;
        r_y2[0]          <= n_y2;
        r_z2[0]          <= n_z2;
        r_m2[0].path     <= r_g2_m.path;
        r_m2[0].near_rot <= r_g2_m.near_rot;
        r_m2[0].near_arr <= r_g2_m.near_arr;
        r_m2[0].zero     <= (r_bx == '0) && (r_by == '0);
        r_m2[0].yaw      <= r_g2_yaw;
        r_m2[0].vel      <= '0;
        r_vql            <= 34'(r_fg) * 34'(r_bx[17:0]);
        r_vqh            <= 34'($signed({1'b0, r_fg})) * 34'($signed(r_bx[34:18]));
    end

    // round, then clamp; the lower bound wins when the bounds cross
    logic [51:0]        n_vsum;
    logic signed [31:0] n_v32;
    logic signed [15:0] n_vel;
    always_comb begin
        n_vsum = (52'(r_vqh) << 18) + 52'(r_vql) + 52'(1 << 19);
        n_v32  = $signed(n_vsum[51:20]);
        n_vel  = n_v32[15:0];
        if (n_v32 > 32'(r_su)) n_vel = r_su;
        if (n_v32 < 32'(r_sl) || (n_v32 > 32'(r_su) && r_sl > r_su)) n_vel = r_sl;
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic2
        logic signed [ggvc_pkg::XW2-1:0] xs, ys;
        ggvc_pkg::t_m2                   n_m2;
        assign xs = r_x2[i] >>> i;
        assign ys = r_y2[i] >>> i;

        // first stage picks up the clamped speed
        always_comb begin
            n_m2 = r_m2[i];
            if (i == 0) n_m2.vel = n_vel;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v2[i+1] <= 1'b0;
            else          r_v2[i+1] <= r_v2[i];
        end

        always_ff @(posedge i_clk) begin
            r_m2[i+1] <= n_m2;
            if (r_y2[i][ggvc_pkg::XW2-1]) begin
                r_x2[i+1] <= r_x2[i] - ys;
                r_y2[i+1] <= r_y2[i] + xs;
                r_z2[i+1] <= r_z2[i] - ggvc_pkg::atan_q(i);
            end else begin
                r_x2[i+1] <= r_x2[i] + ys;
                r_y2[i+1] <= r_y2[i] - xs;
                r_z2[i+1] <= r_z2[i] + ggvc_pkg::atan_q(i);
            end
        end
    end

    // ---------------- F1: heading error select and wrap ----------------
    logic signed [ggvc_pkg::DW-1:0] n_dfin, n_dyaw;
    always_comb begin
        n_dfin = (29'(r_fh) <<< 11) - 29'(r_m2[N].yaw);
        if (n_dfin > ggvc_pkg::PI_Q)       n_dfin = n_dfin - ggvc_pkg::TWO_PI_Q;
        else if (n_dfin < -ggvc_pkg::PI_Q) n_dfin = n_dfin + ggvc_pkg::TWO_PI_Q;
        if (r_m2[N].near_rot)  n_dyaw = n_dfin;
        else if (r_m2[N].zero) n_dyaw = '0;
        else                   n_dyaw = 29'(r_z2[N]);
    end

    logic                           r_f1_v, r_f2_v, r_out_v;
    ggvc_pkg::t_m2                  r_f1_m;
    logic signed [ggvc_pkg::DW-1:0] r_dyaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_f1_v  <= r_v2[N];
            r_f2_v  <= r_f1_v;
            r_out_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_m <= r_m2[N];
        r_dyaw <= n_dyaw;
    end

    // ---------------- F2: turn gain product, arrival test ----------------
    logic signed [ggvc_pkg::DW-1:0] n_adyaw;
    assign n_adyaw = r_dyaw[ggvc_pkg::DW-1] ? -r_dyaw : r_dyaw;

    logic signed [45:0] r_rprod;
    logic               r_f2_path, r_reached;
    logic signed [15:0] r_f2_vel;

    always_ff @(posedge i_clk) begin
        r_rprod   <= 46'($signed({1'b0, r_tg})) * 46'(r_dyaw);
        r_reached <= r_f1_m.near_arr && (n_adyaw < $signed(29'({r_htol, 11'b0})));
        r_f2_path <= r_f1_m.path;
        r_f2_vel  <= r_f1_m.vel;
    end

    // ---------------- F3: round, saturate, drive the result beat ----------------
    logic [45:0]        n_rsum;
    logic signed [17:0] n_r18;
    logic signed [15:0] n_rate;
    ggvc_pkg::t_res     n_res, r_res;

    always_comb begin
        n_rsum = 46'(r_rprod) + 46'(1 << 27);
        n_r18  = $signed(n_rsum[45:28]);
        n_rate = n_r18[15:0];
        if (n_r18 > 18'sd32767)  n_rate = 16'sh7FFF;
        if (n_r18 < -18'sd32768) n_rate = 16'sh8000;
        n_res = '0;
        if (r_f2_path) begin
            if (r_reached) begin
                n_res.arrived = 1'b1;
            end else begin
                n_res.forward_speed = r_f2_vel;
                n_res.yaw_rate      = n_rate;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_out_v;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching command beat");

    a_arrived_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.arrived) |->
            (o_res.forward_speed == 16'sd0) && (o_res.yaw_rate == 16'sd0))
        else $error("goal reached with nonzero command");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g2_v |=> r_v2[0])
        else $error("beat lost between gain stage and bearing CORDIC");
`endif

endmodule
